// ===== design/hmp_to_smf_track_transcoder_defines.svh =====
// Assertion macros used by the transcoder's result sequencer, h2s_back.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef HMP_TO_SMF_TRACK_TRANSCODER_DEFINES_SVH
`define HMP_TO_SMF_TRACK_TRANSCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define H2S_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define H2S_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define H2S_ASSERT(lbl, prop, msg)
`define H2S_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/h2s_pkg.sv =====
// Types, constants and helpers for the HMP to SMF track transcoder.
// No dependencies; used by every module of the block.
package h2s_pkg;

	localparam int MAX_DELTA_GROUPS = 4;
	localparam int DCNT_W = (MAX_DELTA_GROUPS > 1) ? $clog2(MAX_DELTA_GROUPS) : 1;
	localparam int NB_W = $clog2(MAX_DELTA_GROUPS + 1);
	localparam int SH_N = (MAX_DELTA_GROUPS > 1) ? MAX_DELTA_GROUPS - 1 : 1;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] META_CMD = 8'hFF;
	localparam logic [7:0] META_EOT = 8'h2F;

	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON = 4'h9;
	localparam logic [3:0] NIB_POLY_AT = 4'hA;
	localparam logic [3:0] NIB_CTRL = 4'hB;
	localparam logic [3:0] NIB_PROG = 4'hC;
	localparam logic [3:0] NIB_CHAN_AT = 4'hD;
	localparam logic [3:0] NIB_BEND = 4'hE;

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_CMD,
		PH_DATA,
		PH_META_KIND,
		PH_META_LEN,
		PH_META_BODY,
		PH_EOT,
		PH_CLOSED
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_DELTA = 3'd1,
		ERR_CMD = 3'd2,
		ERR_EOT_SIZE = 3'd3,
		ERR_LENGTH = 3'd4
	} err_t;

	// One queue entry: the bytes one input word produces, plus the closing result.
	typedef struct packed {
		logic clr;
		logic done;
		err_t err;
		logic [NB_W-1:0] nb;
		logic [MAX_DELTA_GROUPS-1:0][7:0] bytes;
	} job_t;

	function automatic logic [1:0] cmd_need(input logic [3:0] nib);
		logic [1:0] need;
		case (nib)
			NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_BEND: need = 2'd2;
			NIB_PROG, NIB_CHAN_AT: need = 2'd1;
			default: need = 2'd0;
		endcase
		return need;
	endfunction

endpackage

// ===== design/h2s_hmp_if.sv =====
// Input channel of the transcoder: one HMP track byte per word.
// No dependencies.
interface h2s_hmp_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic first_of_track;
	logic last_of_track;

	modport source(output valid, in_byte, first_of_track, last_of_track, input ready);
	modport sink(input valid, in_byte, first_of_track, last_of_track, output ready);
endinterface

// ===== design/h2s_smf_if.sv =====
// Output channel of the transcoder: one SMF result per word.
// No dependencies.
interface h2s_smf_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic byte_valid;
	logic track_done;
	logic [31:0] track_length;
	logic [2:0] error_code;
	logic run_last;

	modport source(output valid, out_byte, byte_valid, track_done, track_length,
		error_code, run_last, input ready);
	modport sink(input valid, out_byte, byte_valid, track_done, track_length,
		error_code, run_last, output ready);
endinterface

// ===== design/hmp_to_smf_track_transcoder.sv =====
// Top level of the HMP to SMF track transcoder.
// Depends on h2s_pkg, h2s_hmp_if, h2s_smf_if, h2s_front, h2s_queue and h2s_back.
//
// Usage:
//   hmp carries one HMP track body byte per word, with first_of_track on the first
//   byte of a track and last_of_track on the final byte of its declared length.
//   smf carries the results: SMF bytes with byte_valid set, and on the closing
//   result track_done with the track's byte count and error code. run_last marks
//   the last result caused by one input word.
// Timing:
//   The parser takes one input word per cycle unless the queue is full, and writes
//   its results as one entry into a four-entry queue. The sequencer drains one result
//   per cycle into the output register while that register is empty or being taken.
//   A word yields zero to five results; a delta time of n groups gives n results in
//   one entry, and the output port sets the sustained rate.
// Reset and stalls:
//   Reset empties the queue and output register and puts the parser at the start
//   of a delta time. When smf.ready is low the output holds its word; the queue
//   fills behind it and hmp.ready drops only once all four entries are taken.
module hmp_to_smf_track_transcoder (
	input logic clk,
	input logic arst_n,
	h2s_hmp_if.sink hmp,
	h2s_smf_if.source smf
);

	logic full;
	logic push;
	h2s_pkg::job_t push_job;
	logic pop;
	logic head_valid;
	h2s_pkg::job_t head;

	h2s_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.hmp(hmp),
		.full(full),
		.push(push),
		.push_job(push_job)
	);

	h2s_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(full),
		.pop(pop),
		.head_valid(head_valid),
		.head(head)
	);

	h2s_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.smf(smf)
	);

endmodule

// ===== design/h2s_front.sv =====
// Front end: parses HMP track bytes and turns each one that yields results into a queue entry.
// Depends on h2s_pkg and h2s_hmp_if.
module h2s_front (
	input logic clk,
	input logic arst_n,
	h2s_hmp_if.sink hmp,
	input logic full,
	output logic push,
	output h2s_pkg::job_t push_job
);

	h2s_pkg::phase_t ph_q, ph, n_ph;
	logic [h2s_pkg::DCNT_W-1:0] dc_q, dc, n_dc;
	logic [7:0] rc_q, rc, n_rc;
	logic [7:0] br_q, br, n_br;
	logic [7:0] mk_q, mk, n_mk;
	h2s_pkg::err_t err_q, err, n_err;
	logic clr_pend_q;
	logic [6:0] sh_q [h2s_pkg::SH_N];
	logic shift_in;
	logic accept;
	logic [1:0] need;
	logic [7:0] b;
	h2s_pkg::job_t job;

	assign hmp.ready = !full;
	assign accept = hmp.valid && hmp.ready;
	assign b = hmp.in_byte;

	always_comb begin
		// A first word restarts the track before the byte itself is parsed.
		ph = hmp.first_of_track ? h2s_pkg::PH_DELTA : ph_q;
		dc = hmp.first_of_track ? '0 : dc_q;
		rc = hmp.first_of_track ? '0 : rc_q;
		br = hmp.first_of_track ? '0 : br_q;
		mk = hmp.first_of_track ? '0 : mk_q;
		err = hmp.first_of_track ? h2s_pkg::ERR_NONE : err_q;
		n_ph = ph;
		n_dc = dc;
		n_rc = rc;
		n_br = br;
		n_mk = mk;
		n_err = err;
		shift_in = 1'b0;
		need = h2s_pkg::cmd_need(b[7:4]);
		job = '0;
		job.clr = hmp.first_of_track || clr_pend_q;
		if (ph != h2s_pkg::PH_CLOSED) begin
			if (err == h2s_pkg::ERR_NONE) begin
				case (ph)
					h2s_pkg::PH_EOT: n_err = h2s_pkg::ERR_LENGTH;
					h2s_pkg::PH_DELTA: begin
						if (b[7]) begin
							// Newest group goes out first; older groups follow from the shift line.
							job.nb = h2s_pkg::NB_W'(dc) + h2s_pkg::NB_W'(1);
							job.bytes[0] = {(dc != '0), b[6:0]};
							for (int j = 1; j < h2s_pkg::MAX_DELTA_GROUPS; j++) begin
								job.bytes[j] = {(h2s_pkg::DCNT_W'(j) < dc), sh_q[j-1]};
							end
							n_dc = '0;
							n_ph = h2s_pkg::PH_CMD;
						end else if ({1'b0, dc} + (h2s_pkg::DCNT_W+1)'(1) >=
								(h2s_pkg::DCNT_W+1)'(h2s_pkg::MAX_DELTA_GROUPS)) begin
							n_err = h2s_pkg::ERR_DELTA;
						end else begin
							shift_in = 1'b1;
							n_dc = dc + h2s_pkg::DCNT_W'(1);
						end
					end
					h2s_pkg::PH_CMD: begin
						if (b == h2s_pkg::META_CMD) begin
							job.nb = h2s_pkg::NB_W'(1);
							job.bytes[0] = b;
							n_ph = h2s_pkg::PH_META_KIND;
						end else if (need == 2'd0) begin
							n_err = h2s_pkg::ERR_CMD;
						end else begin
							if (b != rc) begin
								job.nb = h2s_pkg::NB_W'(1);
								job.bytes[0] = b;
							end
							n_rc = b;
							n_br = {6'b0, need};
							n_ph = h2s_pkg::PH_DATA;
						end
					end
					h2s_pkg::PH_DATA, h2s_pkg::PH_META_BODY: begin
						job.nb = h2s_pkg::NB_W'(1);
						job.bytes[0] = b;
						if (br <= 8'd1) begin
							n_br = '0;
							n_ph = h2s_pkg::PH_DELTA;
						end else begin
							n_br = br - 8'd1;
						end
					end
					h2s_pkg::PH_META_KIND: begin
						job.nb = h2s_pkg::NB_W'(1);
						job.bytes[0] = b;
						n_mk = b;
						n_ph = h2s_pkg::PH_META_LEN;
					end
					h2s_pkg::PH_META_LEN: begin
						job.nb = h2s_pkg::NB_W'(1);
						job.bytes[0] = b;
						n_br = b;
						if (mk == h2s_pkg::META_EOT) begin
							if (b != 8'd0) n_err = h2s_pkg::ERR_EOT_SIZE;
							else n_ph = h2s_pkg::PH_EOT;
						end else begin
							n_ph = (b != 8'd0) ? h2s_pkg::PH_META_BODY : h2s_pkg::PH_DELTA;
						end
					end
					default: n_ph = h2s_pkg::PH_DELTA;
				endcase
			end
			if (hmp.last_of_track) begin
				// The track may end only between items or right after end of track.
				if (n_err == h2s_pkg::ERR_NONE && n_ph != h2s_pkg::PH_EOT &&
						!(n_ph == h2s_pkg::PH_DELTA && n_dc == '0))
					n_err = h2s_pkg::ERR_LENGTH;
				job.done = 1'b1;
				n_ph = h2s_pkg::PH_CLOSED;
			end
		end
		job.err = n_err;
	end

	assign push = accept && (job.nb != '0 || job.done);
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= h2s_pkg::PH_DELTA;
			dc_q <= '0;
			rc_q <= '0;
			br_q <= '0;
			mk_q <= '0;
			err_q <= h2s_pkg::ERR_NONE;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			ph_q <= n_ph;
			dc_q <= n_dc;
			rc_q <= n_rc;
			br_q <= n_br;
			mk_q <= n_mk;
			err_q <= n_err;
			// A silent first word still has to restart the byte count downstream.
			if (push) clr_pend_q <= 1'b0;
			else if (hmp.first_of_track) clr_pend_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && shift_in) begin
			sh_q[0] <= b[6:0];
			for (int i = 1; i < h2s_pkg::SH_N; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

endmodule

// ===== design/h2s_queue.sv =====
// Short entry queue between the parser and the result sequencer.
// Depends on h2s_pkg.
module h2s_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input h2s_pkg::job_t push_job,
	output logic full,
	input logic pop,
	output logic head_valid,
	output h2s_pkg::job_t head
);

	h2s_pkg::job_t mem_q [h2s_pkg::QDEPTH];
	logic [h2s_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [h2s_pkg::QCNT_W-1:0] cnt_q;
	logic do_pop;

	assign full = (cnt_q == h2s_pkg::QCNT_W'(h2s_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + h2s_pkg::QPTR_W'(1);
			if (do_pop) rd_q <= rd_q + h2s_pkg::QPTR_W'(1);
			if ((push && !full) && !do_pop) cnt_q <= cnt_q + h2s_pkg::QCNT_W'(1);
			else if (!(push && !full) && do_pop) cnt_q <= cnt_q - h2s_pkg::QCNT_W'(1);
		end
	end

endmodule

// ===== design/h2s_back.sv =====
// Sequencer: walks queue entries one result per cycle into the output register when free.
// Depends on h2s_pkg, h2s_smf_if and the assertion macro header.
`include "hmp_to_smf_track_transcoder_defines.svh"
module h2s_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input h2s_pkg::job_t head,
	output logic pop,
	h2s_smf_if.source smf
);

	logic [h2s_pkg::NB_W-1:0] idx_q;
	logic ov_q;
	logic [7:0] obyte_q;
	logic bval_q;
	logic done_q;
	logic [31:0] cnt_q;
	h2s_pkg::err_t err_q;
	logic rlast_q;

	logic is_byte;
	logic last;
	logic load;
	logic [31:0] base;
	logic [h2s_pkg::NB_W:0] total;

	assign is_byte = idx_q < head.nb;
	assign total = {1'b0, head.nb} + (h2s_pkg::NB_W+1)'(head.done);
	assign last = ({1'b0, idx_q} + (h2s_pkg::NB_W+1)'(1)) == total;
	assign load = head_valid && (!ov_q || smf.ready);
	assign pop = load && last;
	// The first result of a new track counts from zero.
	assign base = (head.clr && idx_q == '0) ? 32'd0 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
				idx_q <= last ? '0 : idx_q + h2s_pkg::NB_W'(1);
				cnt_q <= base + 32'(is_byte);
			end else if (smf.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q <= is_byte ? head.bytes[idx_q[h2s_pkg::DCNT_W-1:0]] : 8'd0;
			bval_q <= is_byte;
			done_q <= !is_byte;
			err_q <= is_byte ? h2s_pkg::ERR_NONE : head.err;
			rlast_q <= last;
		end
	end

	assign smf.valid = ov_q;
	assign smf.out_byte = obyte_q;
	assign smf.byte_valid = bval_q;
	assign smf.track_done = done_q;
	assign smf.track_length = cnt_q;
	assign smf.error_code = err_q;
	assign smf.run_last = rlast_q;

	`H2S_NEVER(a_byte_and_close, ov_q && bval_q && done_q, "byte result marked as track close")
	`H2S_ASSERT(a_err_only_on_close, ov_q && !done_q |-> err_q == h2s_pkg::ERR_NONE, "error on byte result")
	`H2S_ASSERT(a_idx_in_entry, head_valid |-> idx_q <= head.nb, "result index past entry")
	`H2S_ASSERT(a_pop_rewinds, pop |=> idx_q == '0, "index not rewound after entry")

endmodule

// ===== verif/h2s_smf_checker.sv =====
// Checker for the HMP to SMF track transcoder: predicts SMF words from accepted HMP words.
// Depends on h2s_pkg, h2s_hmp_if and h2s_smf_if; only watches the channels.
module h2s_smf_checker
	import h2s_pkg::*;
(
	input logic clk,
	input logic arst_n,
	h2s_hmp_if hmp,
	h2s_smf_if smf,
	output int mismatches,
	output int outstanding
);

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic track_done;
		logic [31:0] track_length;
		logic [2:0] error_code;
		logic run_last;
	} smf_word_t;

	smf_word_t smf_due[$];
	int fail_count = 0;

	phase_t phase;
	logic [6:0] delta_buf [MAX_DELTA_GROUPS];
	int unsigned delta_n;
	logic [7:0] status_byte;
	logic [7:0] data_left;
	logic [7:0] meta_type;
	logic [31:0] byte_count;
	err_t track_err;

	assign mismatches = fail_count;

	function automatic void start_track();
		phase = PH_DELTA;
		delta_n = 0;
		status_byte = 8'h00;
		data_left = 8'h00;
		meta_type = 8'h00;
		byte_count = 32'd0;
		track_err = ERR_NONE;
	endfunction

	function automatic void push_word(input logic [7:0] v, input logic is_byte,
		input logic is_close);
		smf_word_t w;
		if (is_byte) byte_count = byte_count + 32'd1;
		w.out_byte = is_byte ? v : 8'h00;
		w.byte_valid = is_byte;
		w.track_done = is_close;
		w.track_length = byte_count;
		w.error_code = track_err;
		w.run_last = 1'b0;
		smf_due.insert(smf_due.size(), w);
	endfunction

	// Works out every SMF word that one accepted HMP word causes.
	function automatic void convert_byte(input logic [7:0] b, input logic sof,
		input logic eof);
		int base;
		int unsigned k;
		logic [1:0] need;
		smf_word_t w;
		base = smf_due.size();
		if (sof) start_track();
		if (phase == PH_CLOSED) return;
		if (track_err == ERR_NONE) begin
			case (phase)
				PH_EOT: track_err = ERR_LENGTH;
				PH_DELTA: begin
					if (b[7]) begin
						// Groups leave in reverse order; all but the final one carry the
						// continuation bit.
						delta_buf[delta_n] = b[6:0];
						for (k = 0; k <= delta_n; k++)
							push_word({k != delta_n, delta_buf[delta_n - k]}, 1'b1, 1'b0);
						delta_n = 0;
						phase = PH_CMD;
					end else if (delta_n + 1 >= MAX_DELTA_GROUPS) begin
						track_err = ERR_DELTA;
					end else begin
						delta_buf[delta_n] = b[6:0];
						delta_n++;
					end
				end
				PH_CMD: begin
					if (b == META_CMD) begin
						push_word(b, 1'b1, 1'b0);
						phase = PH_META_KIND;
					end else begin
						if (b[7:4] == NIB_PROG || b[7:4] == NIB_CHAN_AT) need = 2'd1;
						else if (b[7:4] >= NIB_NOTE_OFF && b[7:4] <= NIB_BEND) need = 2'd2;
						else need = 2'd0;
						if (need == 2'd0) begin
							track_err = ERR_CMD;
						end else begin
							if (b != status_byte) push_word(b, 1'b1, 1'b0);
							status_byte = b;
							data_left = {6'd0, need};
							phase = PH_DATA;
						end
					end
				end
				PH_DATA, PH_META_BODY: begin
					push_word(b, 1'b1, 1'b0);
					if (data_left <= 8'd1) begin
						data_left = 8'h00;
						phase = PH_DELTA;
					end else begin
						data_left = data_left - 8'd1;
					end
				end
				PH_META_KIND: begin
					push_word(b, 1'b1, 1'b0);
					meta_type = b;
					phase = PH_META_LEN;
				end
				PH_META_LEN: begin
					push_word(b, 1'b1, 1'b0);
					data_left = b;
					if (meta_type == META_EOT) begin
						if (b != 8'h00) track_err = ERR_EOT_SIZE;
						else phase = PH_EOT;
					end else begin
						phase = (b != 8'h00) ? PH_META_BODY : PH_DELTA;
					end
				end
				default: phase = PH_DELTA;
			endcase
		end
		if (eof) begin
			if (track_err == ERR_NONE && phase != PH_EOT && !(phase == PH_DELTA && delta_n == 0))
				track_err = ERR_LENGTH;
			push_word(8'h00, 1'b0, 1'b1);
			phase = PH_CLOSED;
		end
		if (smf_due.size() > base) begin
			w = smf_due[smf_due.size() - 1];
			w.run_last = 1'b1;
			smf_due[smf_due.size() - 1] = w;
		end
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		smf_word_t due;
		if (!arst_n) begin
			smf_due.delete();
			start_track();
			outstanding <= 0;
		end else begin
			// Output words are checked first; a word accepted at this edge cannot have caused them.
			if (smf.valid && smf.ready) begin
				if (smf_due.size() == 0) begin
					fail_count++;
					$error("SMF word with no expectation waiting");
				end else begin
					due = smf_due.pop_front();
					compare_field("out_byte", due.out_byte, smf.out_byte);
					compare_field("byte_valid", due.byte_valid, smf.byte_valid);
					compare_field("track_done", due.track_done, smf.track_done);
					compare_field("track_length", due.track_length, smf.track_length);
					compare_field("error_code", due.error_code, smf.error_code);
					compare_field("run_last", due.run_last, smf.run_last);
				end
			end
			if (hmp.valid && hmp.ready)
				convert_byte(hmp.in_byte, hmp.first_of_track, hmp.last_of_track);
			outstanding <= smf_due.size();
		end
	end

endmodule

// ===== verif/hmp_to_smf_track_transcoder_tb.sv =====
// Testbench top for the HMP to SMF track transcoder: drives HMP tracks and a stalling sink.
// Depends on h2s_pkg, the channel interfaces, the transcoder and h2s_smf_checker.
module hmp_to_smf_track_transcoder_tb;
	import h2s_pkg::*;

	typedef enum {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_CHOKED
	} rx_mode_t;

	typedef enum {
		FLAW_BAD_CMD,
		FLAW_LONG_DELTA,
		FLAW_EOT_SIZE,
		FLAW_AFTER_EOT,
		FLAW_CUT,
		FLAW_NO_EOT,
		FLAW_NONE
	} track_flaw_t;

	localparam int RANDOM_ITEMS = 120;
	localparam int CLK_HALF = 6;
	localparam int LIMIT_CYCLES = 200000;

	logic clk;
	logic arst_n;
	int mismatches;
	int outstanding;
	logic [7:0] track_bytes[$];
	logic [7:0] gen_status;
	int burst_left = 0;
	int tracked_items = 0;

	h2s_hmp_if hmp();
	h2s_smf_if smf();

	hmp_to_smf_track_transcoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.hmp(hmp),
		.smf(smf)
	);

	h2s_smf_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.hmp(hmp),
		.smf(smf),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	// The sink switches between stall patterns, holding each for a span of random length.
	initial begin
		rx_mode_t mode;
		int span;
		int period;
		int low_len;
		smf.ready <= 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 150);
			period = $urandom_range(2, 8);
			low_len = $urandom_range(1, period - 1);
			for (int c = 0; c < span; c++) begin
				@(posedge clk);
				case (mode)
					RX_OPEN: smf.ready <= 1'b1;
					RX_COIN: smf.ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: smf.ready <= (c % period) >= low_len;
					default: smf.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic sof, input logic eof);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				hmp.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		hmp.valid <= 1'b1;
		hmp.in_byte <= b;
		hmp.first_of_track <= sof;
		hmp.last_of_track <= eof;
		@(posedge clk);
		while (!hmp.ready) @(posedge clk);
		burst_left--;
	endtask

	task automatic send_track();
		for (int i = 0; i < track_bytes.size(); i++)
			send_word(track_bytes[i], i == 0, i == track_bytes.size() - 1);
		tracked_items += track_bytes.size();
	endtask

	function automatic void add_byte(input logic [7:0] v);
		track_bytes.insert(track_bytes.size(), v);
	endfunction

	// A delta time of the given number of groups; only the final group has the top bit set.
	function automatic void add_delta(input int groups);
		repeat (groups - 1) add_byte(8'($urandom_range(0, 127)));
		add_byte(8'h80 | 8'($urandom_range(0, 127)));
	endfunction

	function automatic void add_event();
		logic [7:0] head;
		int len;
		add_delta(($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, MAX_DELTA_GROUPS));
		if ($urandom_range(0, 9) < 7) begin
			// Reuse the last command half of the time so running status gets exercised.
			if (gen_status != 8'h00 && $urandom_range(0, 1) == 1)
				head = gen_status;
			else
				head = {4'($urandom_range(NIB_NOTE_OFF, NIB_BEND)), 4'($urandom_range(0, 15))};
			gen_status = head;
			add_byte(head);
			len = (head[7:4] == NIB_PROG || head[7:4] == NIB_CHAN_AT) ? 1 : 2;
		end else begin
			add_byte(META_CMD);
			head = 8'($urandom_range(0, 255));
			if (head == META_EOT) head = 8'h01;
			add_byte(head);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
			add_byte(8'(len));
		end
		repeat (len) add_byte(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		track_flaw_t flaw;
		int keep;
		int n_events;
		int pick;
		hmp.valid <= 1'b0;
		hmp.in_byte <= 8'h00;
		hmp.first_of_track <= 1'b0;
		hmp.last_of_track <= 1'b0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Clean track: a four-group delta, running status, a text meta and end of track.
		track_bytes = '{8'h80, 8'h9F, 8'h00, 8'h7F, 8'h00, 8'h7F, 8'h7F, 8'hFF,
			8'h9F, 8'h01, 8'h02, 8'h80, 8'hFF, 8'h01, 8'h01, 8'h41,
			8'h80, 8'hFF, 8'h2F, 8'h00};
		send_track();
		// Overlong delta, then a word after the track has closed.
		track_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h90};
		send_track();
		send_word(8'hFF, 1'b0, 1'b0);
		// Bad command that also closes the track.
		track_bytes = '{8'h80, 8'hF5};
		send_track();

		tracked_items = 0;
		while (tracked_items < RANDOM_ITEMS) begin
			track_bytes.delete();
			gen_status = 8'h00;
			n_events = $urandom_range(0, 5);
			repeat (n_events) add_event();
			pick = $urandom_range(0, 11);
			flaw = (pick < 6) ? track_flaw_t'(pick) : FLAW_NONE;
			case (flaw)
				FLAW_BAD_CMD: begin
					add_delta(1);
					add_byte(($urandom_range(0, 1) == 1) ?
						8'($urandom_range(0, 127)) : 8'($urandom_range(240, 254)));
					add_event();
				end
				FLAW_LONG_DELTA: begin
					repeat (MAX_DELTA_GROUPS) add_byte(8'($urandom_range(0, 127)));
					add_event();
				end
				FLAW_EOT_SIZE: begin
					add_delta(1);
					add_byte(META_CMD);
					add_byte(META_EOT);
					add_byte(8'($urandom_range(1, 255)));
					repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
				end
				FLAW_AFTER_EOT: begin
					add_delta(1);
					add_byte(META_CMD);
					add_byte(META_EOT);
					add_byte(8'h00);
					repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
				end
				FLAW_CUT: begin
					add_delta(1);
					add_byte(META_CMD);
					add_byte(META_EOT);
					add_byte(8'h00);
					keep = $urandom_range(1, track_bytes.size());
					while (track_bytes.size() > keep) void'(track_bytes.pop_back());
				end
				FLAW_NO_EOT: begin
				end
				default: begin
					add_delta(1);
					add_byte(META_CMD);
					add_byte(META_EOT);
					add_byte(8'h00);
				end
			endcase
			if (track_bytes.size() == 0) add_delta(1);
			send_track();
			// Words between tracks are ignored by the block.
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 2))
					send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
		end

		hmp.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== hmp_to_smf_track_transcoder.f =====
+incdir+design
design/h2s_pkg.sv
design/h2s_hmp_if.sv
design/h2s_smf_if.sv
design/h2s_front.sv
design/h2s_queue.sv
design/h2s_back.sv
design/hmp_to_smf_track_transcoder.sv
verif/h2s_smf_checker.sv
verif/hmp_to_smf_track_transcoder_tb.sv
